>>> sv/gate_show_sequencer_defines.svh
// Assertion macros for the gate show sequencer.
`ifndef GATE_SHOW_SEQUENCER_DEFINES_SVH
`define GATE_SHOW_SEQUENCER_DEFINES_SVH

`ifndef ASSERT_OFF
`define GSS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define GSS_ASSERT_NORST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GSS_ASSERT(lbl, clk, rst, prop, msg)
`define GSS_ASSERT_NORST(lbl, clk, prop, msg)
`endif

`endif

>>> sv/gss_pkg.sv
// Types, codes and helpers for the gate show sequencer.
package gss_pkg;

  localparam int S_DATA_W = 40;
  localparam int S_USER_W = 3;
  localparam int M_DATA_W = 16;
  localparam int TIME_W   = 32;

  localparam logic [TIME_W-1:0] OPEN_TIME_RESET = 32'd60000;

  localparam logic [2:0] REQ_POLL   = 3'd0;
  localparam logic [2:0] REQ_OPEN   = 3'd1;
  localparam logic [2:0] REQ_LIGHTS = 3'd2;
  localparam logic [2:0] REQ_PLAY   = 3'd3;
  localparam logic [2:0] REQ_SKIP   = 3'd4;
  localparam logic [2:0] REQ_STOP   = 3'd5;

  localparam logic [1:0] DOOR_NONE  = 2'd0;
  localparam logic [1:0] DOOR_OPEN  = 2'd1;
  localparam logic [1:0] DOOR_CLOSE = 2'd2;

  localparam logic [1:0] LIGHT_NONE = 2'd0;
  localparam logic [1:0] LIGHT_ON   = 2'd1;
  localparam logic [1:0] LIGHT_OFF  = 2'd2;

  localparam logic [2:0] AUD_NONE   = 3'd0;
  localparam logic [2:0] AUD_STOP   = 3'd1;
  localparam logic [2:0] AUD_INTRO  = 3'd2;
  localparam logic [2:0] AUD_PLAY   = 3'd3;
  localparam logic [2:0] AUD_NEXT   = 3'd4;
  localparam logic [2:0] AUD_PAUSE  = 3'd5;
  localparam logic [2:0] AUD_RESUME = 3'd6;

  localparam logic [3:0] CODE_BOOT    = 4'd0;
  localparam logic [3:0] CODE_IDLE    = 4'd1;
  localparam logic [3:0] CODE_INTRO   = 4'd2;
  localparam logic [3:0] CODE_OPENING = 4'd3;
  localparam logic [3:0] CODE_OPEN    = 4'd4;
  localparam logic [3:0] CODE_CLOSING = 4'd5;
  localparam logic [3:0] CODE_LIGHTS  = 4'd6;
  localparam logic [3:0] CODE_PLAYING = 4'd7;
  localparam logic [3:0] CODE_PAUSED  = 4'd8;

  typedef enum logic [8:0] {
    S_BOOT    = 9'b000000001,
    S_IDLE    = 9'b000000010,
    S_INTRO   = 9'b000000100,
    S_OPENING = 9'b000001000,
    S_OPEN    = 9'b000010000,
    S_CLOSING = 9'b000100000,
    S_LIGHTS  = 9'b001000000,
    S_PLAYING = 9'b010000000,
    S_PAUSED  = 9'b100000000
  } state_t;

  typedef struct packed {
    logic [2:0] audio;
    logic [1:0] light;
    logic [1:0] door;
    logic [3:0] cur_state;
  } result_t;

  function automatic logic [3:0] state_code(input state_t s);
    logic [3:0] c;
    unique case (s)
      S_BOOT:    c = CODE_BOOT;
      S_IDLE:    c = CODE_IDLE;
      S_INTRO:   c = CODE_INTRO;
      S_OPENING: c = CODE_OPENING;
      S_OPEN:    c = CODE_OPEN;
      S_CLOSING: c = CODE_CLOSING;
      S_LIGHTS:  c = CODE_LIGHTS;
      S_PLAYING: c = CODE_PLAYING;
      S_PAUSED:  c = CODE_PAUSED;
      default:   c = CODE_BOOT;
    endcase
    return c;
  endfunction

endpackage

>>> sv/gate_show_sequencer.sv
// Gate show sequencer: event-driven show state machine with registered in and out beats.
// An accepted input beat passes the input register and then the result register to m_tvalid.
// Throughput: one beat per cycle unless m_tready stalls the output; the state decode,
// deadline add and compare sit between the input register and the result register.
// Reset (rst, synchronous): boot state, deadline zero, open time 60000 ms,
// both pipeline registers empty.
`include "gate_show_sequencer_defines.svh"

module gate_show_sequencer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // audio_idle, doors_open, doors_closed, now_ms[31:0], zero fill
  input  logic [gss_pkg::S_DATA_W-1:0]  s_tdata,
  // req_type
  input  logic [gss_pkg::S_USER_W-1:0]  s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // cur_state, door_cmd, light_cmd, audio_cmd, zero fill
  output logic [gss_pkg::M_DATA_W-1:0]  m_tdata,
  input  logic                          cfg_we,
  input  logic [gss_pkg::TIME_W-1:0]    cfg_wdata
);
  import gss_pkg::*;

  logic [TIME_W-1:0] open_time_ms;
  state_t            state;
  state_t            state_next;
  logic [TIME_W-1:0] open_deadline;
  logic [TIME_W-1:0] deadline_next;

  logic              s1_valid;
  logic [2:0]        s1_req;
  logic              s1_audio_idle;
  logic              s1_doors_open;
  logic              s1_doors_closed;
  logic [TIME_W-1:0] s1_now;

  logic              adv;
  logic              go_idle;
  logic              go_intro;
  logic              go_closing;
  result_t           res;

  assign adv      = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || adv;
  assign deadline_next = s1_now + open_time_ms;

  always_comb begin
    state_next = state;
    res.door   = DOOR_NONE;
    res.light  = LIGHT_NONE;
    res.audio  = AUD_NONE;
    go_idle    = 1'b0;
    go_intro   = 1'b0;
    go_closing = 1'b0;
    unique case (state)
      S_BOOT: begin
        go_idle = (s1_req == REQ_POLL);
      end
      S_IDLE: begin
        if (s1_req == REQ_OPEN) begin
          go_intro = 1'b1;
        end else if (s1_req == REQ_LIGHTS) begin
          state_next = S_LIGHTS;
          res.light  = LIGHT_ON;
        end else if (s1_req == REQ_PLAY) begin
          state_next = S_PLAYING;
          res.audio  = AUD_PLAY;
        end
      end
      S_INTRO: begin
        if (s1_req == REQ_POLL && s1_audio_idle) begin
          state_next = S_OPENING;
          res.audio  = AUD_PLAY;
        end else if (s1_req == REQ_OPEN) begin
          go_closing = 1'b1;
        end
      end
      S_OPENING: begin
        if (s1_req == REQ_POLL && s1_doors_open) begin
          state_next = S_OPEN;
        end else if (s1_req == REQ_OPEN) begin
          go_closing = 1'b1;
        end
      end
      S_OPEN: begin
        go_closing = (s1_req == REQ_POLL && s1_now > open_deadline) || (s1_req == REQ_OPEN);
      end
      S_CLOSING: begin
        go_idle = (s1_req == REQ_POLL) && s1_doors_closed;
      end
      S_LIGHTS: begin
        // lights off then on within the beat: only on is reported
        go_intro = (s1_req == REQ_OPEN);
        go_idle  = (s1_req == REQ_LIGHTS);
      end
      S_PLAYING: begin
        if (s1_req == REQ_POLL) begin
          if (s1_audio_idle) begin
            res.audio = AUD_PLAY;
          end
        end else if (s1_req == REQ_PLAY) begin
          state_next = S_PAUSED;
          res.audio  = AUD_PAUSE;
        end else if (s1_req == REQ_SKIP) begin
          res.audio = AUD_NEXT;
        end else if (s1_req == REQ_STOP) begin
          go_idle = 1'b1;
        end
      end
      S_PAUSED: begin
        if (s1_req == REQ_PLAY) begin
          state_next = S_PLAYING;
          res.audio  = AUD_RESUME;
        end else if (s1_req == REQ_STOP) begin
          go_idle = 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (go_idle) begin
      state_next = S_IDLE;
      res.door   = DOOR_CLOSE;
      res.audio  = AUD_STOP;
      res.light  = LIGHT_OFF;
    end
    if (go_intro) begin
      state_next = S_INTRO;
      res.door   = DOOR_OPEN;
      res.light  = LIGHT_ON;
      res.audio  = AUD_INTRO;
    end
    if (go_closing) begin
      state_next = S_CLOSING;
      res.door   = DOOR_CLOSE;
    end
    res.cur_state = state_code(state_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      open_time_ms  <= OPEN_TIME_RESET;
      state         <= S_BOOT;
      open_deadline <= '0;
      s1_valid      <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        open_time_ms <= cfg_wdata;
      end
      if (s_tready) begin
        s1_valid <= s_tvalid;
      end
      if (adv) begin
        state <= state_next;
        if (go_intro) begin
          open_deadline <= deadline_next;
        end
      end
      if (adv) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_req          <= s_tuser;
      s1_audio_idle   <= s_tdata[0];
      s1_doors_open   <= s_tdata[1];
      s1_doors_closed <= s_tdata[2];
      s1_now          <= s_tdata[TIME_W+2:3];
    end
    if (adv) begin
      m_tdata <= {{(M_DATA_W - $bits(result_t)){1'b0}}, res};
    end
  end

  `GSS_ASSERT_NORST(a_reset_clears, clk, rst |=> (state == S_BOOT) && !s1_valid && !m_tvalid, "reset did not clear control state")
  `GSS_ASSERT(a_result_matches_state, clk, rst, adv |=> m_tvalid && (m_tdata[3:0] == state_code(state)), "result state differs from state register")
  `GSS_ASSERT(a_deadline_load, clk, rst, adv && go_intro |=> (state == S_INTRO) && (open_deadline == $past(deadline_next)), "deadline not loaded on intro entry")
  `GSS_ASSERT(a_deadline_hold, clk, rst, !(adv && go_intro) |=> $stable(open_deadline), "deadline changed outside intro entry")
  `GSS_ASSERT(a_stall_holds_item, clk, rst, s1_valid && m_tvalid && !m_tready |=> s1_valid && $stable(s1_req) && $stable(state), "held beat lost during output stall")

endmodule

>>> tb/tb_gate_show_sequencer.sv
// Self-checking testbench for the gate show sequencer: directed table, then random phases.
`timescale 1ns / 1ps

module tb_gate_show_sequencer;
  import gss_pkg::*;

  localparam logic [2:0] REQ_SPARE_6 = 3'd6;
  localparam logic [2:0] REQ_SPARE_7 = 3'd7;
  localparam int N_PHASES   = 6;
  localparam int PHASE_BEATS = 180;

  typedef struct {
    logic [2:0]  req;
    logic        ai;
    logic        dop;
    logic        dcl;
    logic [31:0] now;
    bit          known;
    result_t     want;
  } show_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata;
  logic [S_USER_W-1:0] s_tuser;
  logic                m_tvalid;
  logic                m_tready;
  logic [M_DATA_W-1:0] m_tdata;
  logic                cfg_we;
  logic [TIME_W-1:0]   cfg_wdata;

  // predictor state
  logic [3:0]  show_state;
  logic [31:0] open_deadline;
  logic [31:0] hold_ms;

  result_t   pending_results[$];
  show_row_t directed_rows[$];
  int        mismatches  = 0;
  int        beats_in    = 0;
  int        results_out = 0;
  bit        src_steady  = 1'b0;
  bit        snk_steady  = 1'b0;

  gate_show_sequencer dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  initial begin : watchdog
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic result_t idle_cmds();
    result_t r;
    r = '0;
    show_state = CODE_IDLE;
    r.door  = DOOR_CLOSE;
    r.light = LIGHT_OFF;
    r.audio = AUD_STOP;
    return r;
  endfunction

  function automatic result_t intro_cmds(input logic [31:0] now);
    result_t r;
    r = '0;
    show_state    = CODE_INTRO;
    open_deadline = now + hold_ms;
    r.door  = DOOR_OPEN;
    r.light = LIGHT_ON;
    r.audio = AUD_INTRO;
    return r;
  endfunction

  function automatic result_t closing_cmds();
    result_t r;
    r = '0;
    show_state = CODE_CLOSING;
    r.door = DOOR_CLOSE;
    return r;
  endfunction

  function automatic result_t step_show(input logic [2:0] req, input logic ai, input logic dop,
                                        input logic dcl, input logic [31:0] now);
    result_t r;
    r = '0;
    case (show_state)
      CODE_BOOT:
        if (req == REQ_POLL) r = idle_cmds();
      CODE_IDLE:
        if (req == REQ_OPEN) begin
          r = intro_cmds(now);
        end else if (req == REQ_LIGHTS) begin
          show_state = CODE_LIGHTS;
          r.light = LIGHT_ON;
        end else if (req == REQ_PLAY) begin
          show_state = CODE_PLAYING;
          r.audio = AUD_PLAY;
        end
      CODE_INTRO:
        if (req == REQ_POLL && ai) begin
          show_state = CODE_OPENING;
          r.audio = AUD_PLAY;
        end else if (req == REQ_OPEN) begin
          r = closing_cmds();
        end
      CODE_OPENING:
        if (req == REQ_POLL && dop) show_state = CODE_OPEN;
        else if (req == REQ_OPEN) r = closing_cmds();
      CODE_OPEN:
        if ((req == REQ_POLL && now > open_deadline) || req == REQ_OPEN) r = closing_cmds();
      CODE_CLOSING:
        if (req == REQ_POLL && dcl) r = idle_cmds();
      CODE_LIGHTS:
        // off then on in one step reports only on
        if (req == REQ_OPEN) r = intro_cmds(now);
        else if (req == REQ_LIGHTS) r = idle_cmds();
      CODE_PLAYING:
        if (req == REQ_POLL) begin
          if (ai) r.audio = AUD_PLAY;
        end else if (req == REQ_PLAY) begin
          show_state = CODE_PAUSED;
          r.audio = AUD_PAUSE;
        end else if (req == REQ_SKIP) begin
          r.audio = AUD_NEXT;
        end else if (req == REQ_STOP) begin
          r = idle_cmds();
        end
      CODE_PAUSED:
        if (req == REQ_PLAY) begin
          show_state = CODE_PLAYING;
          r.audio = AUD_RESUME;
        end else if (req == REQ_STOP) begin
          r = idle_cmds();
        end
      default: ;
    endcase
    r.cur_state = show_state;
    return r;
  endfunction

  function automatic logic [2:0] pick_request();
    if ($urandom_range(0, 9) < 3) return 3'($urandom_range(0, 7));
    case (show_state)
      CODE_BOOT, CODE_CLOSING: return REQ_POLL;
      CODE_IDLE:
        case ($urandom_range(0, 2))
          0:       return REQ_OPEN;
          1:       return REQ_LIGHTS;
          default: return REQ_PLAY;
        endcase
      CODE_INTRO, CODE_OPENING, CODE_OPEN:
        return ($urandom_range(0, 4) == 0) ? REQ_OPEN : REQ_POLL;
      CODE_LIGHTS: return $urandom_range(0, 1) ? REQ_OPEN : REQ_LIGHTS;
      CODE_PLAYING:
        case ($urandom_range(0, 3))
          0:       return REQ_POLL;
          1:       return REQ_PLAY;
          2:       return REQ_SKIP;
          default: return REQ_STOP;
        endcase
      CODE_PAUSED: return $urandom_range(0, 1) ? REQ_PLAY : REQ_STOP;
      default: return 3'($urandom_range(0, 7));
    endcase
  endfunction

  task automatic add_row(input logic [2:0] req, input logic ai, input logic dop, input logic dcl,
                         input logic [31:0] now, input bit known, input logic [3:0] st,
                         input logic [1:0] door, input logic [1:0] light,
                         input logic [2:0] aud);
    show_row_t row;
    row.req   = req;
    row.ai    = ai;
    row.dop   = dop;
    row.dcl   = dcl;
    row.now   = now;
    row.known = known;
    row.want  = '{audio: aud, light: light, door: door, cur_state: st};
    directed_rows.push_back(row);
  endtask

  task automatic send_beat(input logic [2:0] req, input logic ai, input logic dop,
                           input logic dcl, input logic [31:0] now, input bit known,
                           input result_t want);
    int      gap;
    result_t predicted;
    gap = src_steady ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= {5'b0, now, dcl, dop, ai};
    do @(posedge clk); while (!s_tready);
    predicted = step_show(req, ai, dop, dcl, now);
    pending_results.push_back(known ? want : predicted);
    beats_in++;
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // pipe is two deep; let it settle before touching the register
    repeat (4) @(posedge clk);
  endtask

  task automatic write_hold_time(input logic [31:0] value);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    hold_ms = value;
  endtask

  task automatic check_result(input logic [M_DATA_W-1:0] beat);
    result_t want;
    result_t got;
    got = beat[10:0];
    results_out++;
    if (pending_results.size() == 0) begin
      if (mismatches < 10) $display("unexpected result beat %h", beat);
      mismatches++;
    end else begin
      want = pending_results.pop_front();
      if (got.cur_state != want.cur_state || got.door != want.door ||
          got.light != want.light || got.audio != want.audio || beat[15:11] != '0) begin
        if (mismatches < 10) begin
          $display("result %0d: want state %0d door %0d light %0d audio %0d",
                   results_out, want.cur_state, want.door, want.light, want.audio);
          $display("  got state %0d door %0d light %0d audio %0d fill %h",
                   got.cur_state, got.door, got.light, got.audio, beat[15:11]);
        end
        mismatches++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) check_result(m_tdata);
  end

  initial begin : result_sink
    int gap;
    m_tready = 1'b0;
    @(negedge rst);
    forever begin
      gap = snk_steady ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  initial begin : stimulus
    logic [31:0] ms_now;
    logic [31:0] step_max;
    logic [31:0] setting;
    logic [31:0] now;
    int          n;
    int          p;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    show_state    = CODE_BOOT;
    open_deadline = '0;
    hold_ms       = OPEN_TIME_RESET;

    add_row(REQ_OPEN, 1, 1, 1, 32'd0, 1, CODE_BOOT, DOOR_NONE, LIGHT_NONE, AUD_NONE);
    add_row(REQ_SPARE_7, 1, 1, 1, 32'hFFFF_FFFF, 1, CODE_BOOT, DOOR_NONE, LIGHT_NONE, AUD_NONE);
    add_row(REQ_POLL, 0, 0, 0, 32'd0, 1, CODE_IDLE, DOOR_CLOSE, LIGHT_OFF, AUD_STOP);
    add_row(REQ_SKIP, 1, 1, 1, 32'd5, 1, CODE_IDLE, DOOR_NONE, LIGHT_NONE, AUD_NONE);
    add_row(REQ_SPARE_6, 0, 0, 0, 32'd6, 1, CODE_IDLE, DOOR_NONE, LIGHT_NONE, AUD_NONE);
    add_row(REQ_LIGHTS, 0, 0, 0, 32'd7, 1, CODE_LIGHTS, DOOR_NONE, LIGHT_ON, AUD_NONE);
    // lights off then on: only on shows; deadline wraps past zero
    add_row(REQ_OPEN, 0, 0, 0, 32'hFFFF_FFFF, 1, CODE_INTRO, DOOR_OPEN, LIGHT_ON, AUD_INTRO);
    add_row(REQ_POLL, 0, 1, 1, 32'd10, 0, '0, '0, '0, '0);
    add_row(REQ_POLL, 1, 0, 0, 32'd20, 0, '0, '0, '0, '0);
    add_row(REQ_POLL, 1, 0, 1, 32'd30, 0, '0, '0, '0, '0);
    add_row(REQ_POLL, 0, 1, 0, 32'd40, 0, '0, '0, '0, '0);
    add_row(REQ_POLL, 1, 1, 1, 32'd59999, 0, '0, '0, '0, '0);
    add_row(REQ_POLL, 0, 0, 0, 32'd60000, 0, '0, '0, '0, '0);
    add_row(REQ_POLL, 0, 0, 1, 32'd60001, 0, '0, '0, '0, '0);
    add_row(REQ_PLAY, 0, 0, 0, 32'd60002, 0, '0, '0, '0, '0);
    add_row(REQ_POLL, 1, 0, 0, 32'd60003, 0, '0, '0, '0, '0);
    add_row(REQ_SKIP, 0, 0, 0, 32'd60004, 0, '0, '0, '0, '0);
    add_row(REQ_PLAY, 0, 0, 0, 32'd60005, 0, '0, '0, '0, '0);
    add_row(REQ_SKIP, 1, 1, 1, 32'd60006, 0, '0, '0, '0, '0);
    add_row(REQ_PLAY, 0, 0, 0, 32'd60007, 0, '0, '0, '0, '0);
    add_row(REQ_STOP, 0, 0, 0, 32'd60008, 0, '0, '0, '0, '0);
    add_row(REQ_OPEN, 0, 0, 0, 32'd0, 0, '0, '0, '0, '0);
    add_row(REQ_OPEN, 0, 0, 0, 32'd1, 0, '0, '0, '0, '0);
    add_row(REQ_POLL, 1, 1, 1, 32'hFFFF_FFFF, 0, '0, '0, '0, '0);

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i])
      send_beat(directed_rows[i].req, directed_rows[i].ai, directed_rows[i].dop,
                directed_rows[i].dcl, directed_rows[i].now, directed_rows[i].known,
                directed_rows[i].want);

    ms_now = 32'd0;
    for (p = 0; p < N_PHASES; p++) begin
      case (p)
        0:       begin setting = 32'd0;                       step_max = 32'd4;     end
        1:       begin setting = 32'hFFFF_FFFF;               step_max = 32'd50;    end
        2:       begin setting = 32'd1;                       step_max = 32'd3;     end
        3:       begin setting = 32'($urandom_range(10, 300)); step_max = 32'd60;    end
        4:       begin setting = OPEN_TIME_RESET;             step_max = 32'd20000; end
        default: begin setting = $urandom;                    step_max = 32'd0;     end
      endcase
      write_hold_time(setting);
      for (n = 0; n < PHASE_BEATS; n++) begin
        if (n % 60 == 0) begin
          src_steady = ($urandom_range(0, 3) == 0);
          snk_steady = ($urandom_range(0, 3) == 0);
        end
        if (n == 97) drain_results();
        ms_now = ms_now + 32'($urandom_range(0, step_max));
        case ($urandom_range(0, 49))
          0:       now = 32'd0;
          1:       now = 32'hFFFF_FFFF;
          default: now = (step_max == 0) ? $urandom : ms_now;
        endcase
        send_beat(pick_request(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), now, 1'b0, '0);
      end
    end

    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("%0d input beats and %0d result beats checked over %0d open-time settings",
             beats_in, results_out, N_PHASES + 1);
    $display("%0d mismatches, %0d results still owed", mismatches, pending_results.size());
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
